>>> sv/sha_pkg.sv
// SHA-256 engine package: state machine type, initial hash values, round constants
// and the round and schedule mixing functions. No dependencies.
`default_nettype none
package sha_pkg;

    typedef enum logic [2:0] {
        ST_TAKE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_SEND
    } t_state;

    localparam logic [7:0]  PAD_BYTE      = 8'h80;
    localparam logic [3:0]  LEN_HI_SLOT   = 4'd14;
    localparam logic [3:0]  LEN_LO_SLOT   = 4'd15;
    localparam logic [2:0]  FULL_WORD     = 3'd4;
    localparam logic [5:0]  LAST_ROUND    = 6'd63;
    localparam logic [2:0]  LAST_DIGEST   = 3'd7;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] v;
        case (idx)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  default: v = 32'hc67178f2;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage
`default_nettype wire

>>> sv/sha256_hash_engine_core.sv
// SHA-256 hash engine top level: word gathering, padding sequencer, one-round-per-cycle
// compression unit and digest output. Depends on sha_pkg.
// Message words are taken one per cycle while the sequencer gathers input; a full
// 16-word block then runs the compression rounds and one chain add.
// The final word starts padding at one word per cycle up to the block end, one or two
// compressions, and eight digest words. Synchronous active-low reset restores the
// initial hash values and clears the fill count, bit length and sequencer.
`default_nettype none
module sha256_hash_engine_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_msg_word,
    input  wire logic [2:0]  i_byte_count,
    input  wire logic        i_last_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic             o_digest_last
);
    import sha_pkg::*;

    // Sequencer state.
    t_state r_state, n_state;

    // Chain value, working variables a..h and the 16-word schedule window. The window
    // is a shift line: words enter at the top while gathering, and during compression
    // each round consumes the bottom word and appends the next schedule word.
    logic [31:0] r_chain [0:7];
    logic [31:0] n_chain [0:7];
    logic [31:0] r_work  [0:7];
    logic [31:0] n_work  [0:7];
    logic [31:0] r_sched [0:15];
    logic [31:0] n_sched [0:15];

    logic [3:0]  r_fill,  n_fill;
    logic [63:0] r_bit_len, n_bit_len;
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_out_idx, n_out_idx;

    // Padding bookkeeping. The final word is held and written during padding: a full
    // final word goes in whole first, then the word with the 0x80 byte.
    logic [31:0] r_hold,  n_hold;
    logic [31:0] r_pad,   n_pad;
    logic        r_raw_pend, n_raw_pend;
    logic        r_pad_pend, n_pad_pend;
    logic        r_final, n_final;
    logic        r_len_started, n_len_started;
    logic        r_done, n_done;

    // Shared datapath signals.
    logic        push;
    logic [31:0] push_word;
    logic [2:0]  cnt_sat;
    logic [31:0] keep_mask;
    logic [31:0] pad_mark;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] choose;
    logic [31:0] major;
    logic [31:0] next_sched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_TAKE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= init_hash(3'(i));
            end
            r_fill        <= '0;
            r_bit_len     <= '0;
            r_round       <= '0;
            r_out_idx     <= '0;
            r_raw_pend    <= 1'b0;
            r_pad_pend    <= 1'b0;
            r_final       <= 1'b0;
            r_len_started <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            r_chain       <= n_chain;
            r_fill        <= n_fill;
            r_bit_len     <= n_bit_len;
            r_round       <= n_round;
            r_out_idx     <= n_out_idx;
            r_raw_pend    <= n_raw_pend;
            r_pad_pend    <= n_pad_pend;
            r_final       <= n_final;
            r_len_started <= n_len_started;
            r_done        <= n_done;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_work  <= n_work;
        r_sched <= n_sched;
        r_hold  <= n_hold;
        r_pad   <= n_pad;
    end

    // Byte counts above four mean a full word.
    assign cnt_sat = (i_byte_count > FULL_WORD) ? FULL_WORD : i_byte_count;

    always_comb begin
        case (cnt_sat)
            3'd0: begin
                keep_mask = 32'h0000_0000;
                pad_mark  = {PAD_BYTE, 24'h0};
            end
            3'd1: begin
                keep_mask = 32'hff00_0000;
                pad_mark  = {8'h00, PAD_BYTE, 16'h0};
            end
            3'd2: begin
                keep_mask = 32'hffff_0000;
                pad_mark  = {16'h0, PAD_BYTE, 8'h00};
            end
            3'd3: begin
                keep_mask = 32'hffff_ff00;
                pad_mark  = {24'h0, PAD_BYTE};
            end
            default: begin
                keep_mask = 32'hffff_ffff;
                pad_mark  = {PAD_BYTE, 24'h0};
            end
        endcase
    end

    // One compression round on the working variables, and the schedule word that
    // enters the window sixteen rounds ahead of its use.
    assign choose = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
    assign major  = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2]) ^ (r_work[1] & r_work[2]);
    assign t1     = r_work[7] + big_sigma1(r_work[4]) + choose + round_k(r_round) + r_sched[0];
    assign t2     = big_sigma0(r_work[0]) + major;
    assign next_sched = r_sched[0] + small_sigma0(r_sched[1]) + r_sched[9]
                      + small_sigma1(r_sched[14]);

    always_comb begin
        n_state       = r_state;
        n_chain       = r_chain;
        n_work        = r_work;
        n_sched       = r_sched;
        n_fill        = r_fill;
        n_bit_len     = r_bit_len;
        n_round       = r_round;
        n_out_idx     = r_out_idx;
        n_hold        = r_hold;
        n_pad         = r_pad;
        n_raw_pend    = r_raw_pend;
        n_pad_pend    = r_pad_pend;
        n_final       = r_final;
        n_len_started = r_len_started;
        n_done        = r_done;
        push          = 1'b0;
        push_word     = '0;
        o_stall       = 1'b1;
        o_valid       = 1'b0;
        o_digest_word = r_chain[r_out_idx];
        o_digest_last = (r_out_idx == LAST_DIGEST);

        case (r_state)
            ST_TAKE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (!i_last_word) begin
                        push      = 1'b1;
                        push_word = i_msg_word;
                        n_bit_len = r_bit_len + 64'd32;
                    end else begin
                        n_bit_len     = r_bit_len + {58'd0, cnt_sat, 3'b000};
                        n_hold        = i_msg_word;
                        n_raw_pend    = (cnt_sat == FULL_WORD);
                        n_pad         = (cnt_sat == FULL_WORD) ? {PAD_BYTE, 24'h0}
                                                               : ((i_msg_word & keep_mask) | pad_mark);
                        n_pad_pend    = 1'b1;
                        n_final       = 1'b1;
                        n_len_started = 1'b0;
                        n_state       = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // One padding word per cycle, paused while a filled block is compressed: held
                // word, pad word, zero fill, then the 64-bit length in the last two slots of the closing block.
                push = 1'b1;
                if (r_raw_pend) begin
                    push_word  = r_hold;
                    n_raw_pend = 1'b0;
                end else if (r_pad_pend) begin
                    push_word  = r_pad;
                    n_pad_pend = 1'b0;
                end else if (r_fill == LEN_HI_SLOT) begin
                    push_word     = r_bit_len[63:32];
                    n_len_started = 1'b1;
                end else if (r_fill == LEN_LO_SLOT && r_len_started) begin
                    push_word = r_bit_len[31:0];
                end else begin
                    push_word = '0;
                end
            end
            ST_ROUND: begin
                n_work[7] = r_work[6];
                n_work[6] = r_work[5];
                n_work[5] = r_work[4];
                n_work[4] = r_work[3] + t1;
                n_work[3] = r_work[2];
                n_work[2] = r_work[1];
                n_work[1] = r_work[0];
                n_work[0] = t1 + t2;
                for (int i = 0; i < 15; i++) begin
                    n_sched[i] = r_sched[i + 1];
                end
                n_sched[15] = next_sched;
                n_round     = r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + r_work[i];
                end
                if (r_done) begin
                    n_out_idx = '0;
                    n_state   = ST_SEND;
                end else if (r_final) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_TAKE;
                end
            end
            ST_SEND: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    if (r_out_idx == LAST_DIGEST) begin
                        // Restart from the initial hash values for the next message.
                        for (int i = 0; i < 8; i++) begin
                            n_chain[i] = init_hash(3'(i));
                        end
                        n_fill        = '0;
                        n_bit_len     = '0;
                        n_final       = 1'b0;
                        n_done        = 1'b0;
                        n_len_started = 1'b0;
                        n_state       = ST_TAKE;
                    end else begin
                        n_out_idx = r_out_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_TAKE;
            end
        endcase

        // Word insertion into the window; a full block starts the compression.
        if (push) begin
            for (int i = 0; i < 15; i++) begin
                n_sched[i] = r_sched[i + 1];
            end
            n_sched[15] = push_word;
            n_fill      = r_fill + 4'd1;
            if (r_fill == LEN_LO_SLOT) begin
                n_work  = r_chain;
                n_round = '0;
                n_done  = r_final && r_len_started && !r_raw_pend && !r_pad_pend;
                n_state = ST_ROUND;
            end
        end
    end

endmodule
`default_nettype wire

>>> verif/tb_sha256_hash_engine_core.sv
// Self-checking testbench for sha256_hash_engine_core: drives messages word by word and
// checks every digest word against a SHA-256 predictor kept in a small scoreboard class.
// Depends only on the engine RTL and its package; reads no files.
module tb_sha256_hash_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    // A cycle in which neither channel moves a word counts toward the watchdog. The
    // longest correct quiet stretch is the padding run plus two compressions after a
    // final word, plus receiver stalls.
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 200;
    localparam int RANDOM_WORDS  = 240;

    // One expected digest word as it should leave the engine.
    typedef struct {
        bit [31:0] word;
        bit        last;
    } t_digest_word;

    // Scoreboard: a bit-exact SHA-256 hasher fed by accepted message words, and a queue of
    // the digest words it predicts. Mismatches are counted here.
    class sha256_scoreboard;
        bit [31:0]    round_tab[64];
        bit [31:0]    start_hash[8];
        bit [31:0]    chain[8];
        bit [31:0]    blk[16];
        int           fill;
        bit [63:0]    msg_bits;
        t_digest_word expected_digest_q[$];
        int           mismatches;

        function new();
            round_tab = '{
                32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
                32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
                32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
                32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
                32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
                32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
                32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
                32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
                32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
                32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
                32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
                32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
                32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
                32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
                32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
                32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
            };
            start_hash = '{
                32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
            };
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            chain    = start_hash;
            fill     = 0;
            msg_bits = '0;
        endfunction

        function bit [31:0] ror(bit [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress_block();
            bit [31:0] sched[64];
            bit [31:0] v[8];
            bit [31:0] s0, s1, ch, maj, t1, t2;
            int        t;
            for (t = 0; t < 16; t++)
                sched[t] = blk[t];
            for (t = 16; t < 64; t++) begin
                s0 = ror(sched[t-15], 7) ^ ror(sched[t-15], 18) ^ (sched[t-15] >> 3);
                s1 = ror(sched[t-2], 17) ^ ror(sched[t-2], 19) ^ (sched[t-2] >> 10);
                sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
            end
            v = chain;
            for (t = 0; t < 64; t++) begin
                s1   = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
                ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
                t1   = v[7] + s1 + ch + round_tab[t] + sched[t];
                s0   = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
                maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
                t2   = s0 + maj;
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (t = 0; t < 8; t++)
                chain[t] += v[t];
        endfunction

        function void store_word(bit [31:0] w);
            blk[fill] = w;
            fill++;
            if (fill == 16) begin
                compress_block();
                fill = 0;
            end
        endfunction

        // Takes one accepted message word; a final word queues the eight digest words.
        function void note_word(bit [31:0] w, bit [2:0] cnt, bit last);
            int        nbytes;
            bit [31:0] keep;
            bit [31:0] pad;
            int        k;
            nbytes = (cnt > 3'd4) ? 4 : int'(cnt);
            if (!last) begin
                // A short count on a word that is not the last one is ignored.
                msg_bits += 64'd32;
                store_word(w);
                return;
            end
            msg_bits += 64'(8 * nbytes);
            if (nbytes == 4) begin
                store_word(w);
                pad = 32'h8000_0000;
            end else begin
                keep = (nbytes == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nbytes));
                pad  = (w & keep) | (32'h80 << (24 - 8 * nbytes));
            end
            blk[fill] = pad;
            fill++;
            // No room left for the length: zero fill this block and use one more.
            if (fill > 14) begin
                while (fill < 16) begin
                    blk[fill] = '0;
                    fill++;
                end
                compress_block();
                fill = 0;
            end
            while (fill < 14) begin
                blk[fill] = '0;
                fill++;
            end
            blk[14] = msg_bits[63:32];
            blk[15] = msg_bits[31:0];
            compress_block();
            for (k = 0; k < 8; k++)
                expected_digest_q.push_back('{word: chain[k], last: (k == 7)});
            restart();
        endfunction

        task report_mismatch(string what);
            $display("%0t ns: digest mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_digest(bit [31:0] word, bit last);
            t_digest_word exp_d;
            if (expected_digest_q.size() == 0) begin
                report_mismatch($sformatf("unexpected digest word %08h", word));
                return;
            end
            exp_d = expected_digest_q.pop_front();
            if (word !== exp_d.word)
                report_mismatch($sformatf("digest_word %08h, want %08h", word, exp_d.word));
            if (last !== exp_d.last)
                report_mismatch($sformatf("digest_last %0b, want %0b", last, exp_d.last));
        endtask

        function int pending();
            return expected_digest_q.size();
        endfunction
    endclass

    // Every input of the engine holds a known value from time zero; reset starts asserted.
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [31:0] i_msg_word   = '0;
    logic [2:0]  i_byte_count = '0;
    logic        i_last_word  = 1'b0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_digest_word;
    logic        o_digest_last;

    sha256_scoreboard sb;

    // Idle rates in percent; the stimulus changes them between the three phases.
    int tx_idle_pct = 8;
    int rx_idle_pct = 48;
    int words_sent  = 0;

    sha256_hash_engine_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_msg_word    (i_msg_word),
        .i_byte_count  (i_byte_count),
        .i_last_word   (i_last_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_digest_last (o_digest_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // The receiver stalls at random, one decision per clock edge.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // All values sampled at the rising edge are the ones from before it, since every
    // input is driven by nonblocking assignment; a digest word moves when valid is high
    // and the stall is low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_digest(o_digest_word, o_digest_last);
    end

    // Presents one message word, after a random number of idle cycles, and holds it
    // unchanged until the engine takes it. Valid is left high afterwards so that a
    // following word can go out back to back.
    task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_msg_word   <= w;
        i_byte_count <= cnt;
        i_last_word  <= last;
        do
            @(posedge i_clk);
        while (o_stall);
        sb.note_word(w, cnt, last);
        words_sent++;
    endtask

    // A random message. Half of the lengths are short; a good share land near the block end,
    // where the padding either fits or spills into an extra block, and some span two
    // or more blocks. Non-final words mostly carry a count of four, and the final word
    // takes any count, including the values above four.
    task automatic send_random_message();
        int       n_words;
        int       sel;
        int       i;
        bit [2:0] cnt;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            n_words = $urandom_range(0, 12);
        else if (sel < 8)
            n_words = $urandom_range(12, 15) + 16 * $urandom_range(0, 1);
        else
            n_words = $urandom_range(16, 40);
        for (i = 0; i < n_words; i++) begin
            cnt = ($urandom_range(0, 7) < 6) ? 3'd4 : 3'($urandom_range(0, 7));
            send_word($urandom(), cnt, 1'b0);
        end
        send_word($urandom(), 3'($urandom_range(0, 7)), 1'b1);
    endtask

    // Watchdog: ends the run if no word moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_sha256_hash_engine_core: errors");
        $finish;
    end

    initial begin : stimulus
        int i;
        int random_start;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. An empty message whose word is all ones, so the ignored bytes
        // are all set and the pad byte lands at the first byte.
        send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
        // Three bytes with a set unused low byte, which must be replaced by the pad.
        send_word(32'h6162_63FF, 3'd3, 1'b1);
        // A full final word of zeros: the pad byte starts the next word.
        send_word(32'h0000_0000, 3'd4, 1'b1);
        // A count above four on the final word counts as four.
        send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
        send_word(32'hA5A5_A5A5, 3'd1, 1'b1);
        send_word(32'h5A5A_5A5A, 3'd2, 1'b1);
        // Short and oversized counts on words that are not last are both ignored.
        send_word(32'h0123_4567, 3'd2, 1'b0);
        send_word(32'h89AB_CDEF, 3'd5, 1'b0);
        send_word(32'hDEAD_BEEF, 3'd6, 1'b1);
        // Fourteen words with a full final word: the pad word sits in the high length
        // slot, so the length needs a second block.
        for (i = 0; i < 13; i++)
            send_word($urandom(), 3'd4, 1'b0);
        send_word($urandom(), 3'd4, 1'b1);

        // Random part in three phases: a slow receiver, then a slow sender, then both at
        // full speed.
        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS) begin
            if (words_sent - random_start < RANDOM_WORDS / 3) begin
                tx_idle_pct = 8;
                rx_idle_pct = 48;
            end else if (words_sent - random_start < 2 * RANDOM_WORDS / 3) begin
                tx_idle_pct = 48;
                rx_idle_pct = 8;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_random_message();
        end
        i_valid <= 1'b0;

        // Drain every predicted digest word, then give the engine time to show any
        // stray output before deciding.
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("tb_sha256_hash_engine_core: clean");
        else
            $display("tb_sha256_hash_engine_core: errors");
        $finish;
    end

endmodule

>>> files.f
sv/sha_pkg.sv
sv/sha256_hash_engine_core.sv
verif/tb_sha256_hash_engine_core.sv
